>>> hdl/cia_pkg.sv
// Shared constants, types and operation codes of the complex integer ALU.
// No dependencies; every other file of the block uses this package.
package cia_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RES_W         = 33;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int QW            = PROD_W;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
  typedef logic signed [OPERAND_WIDTH:0]   ext_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [PROD_W:0]          sum_t;
  typedef logic signed [RES_W-1:0]         res_t;
  typedef logic        [QW-1:0]            mag_t;
  typedef logic signed [QW:0]              quo_t;
  typedef logic        [QPTR_W-1:0]        qptr_t;
  typedef logic        [QPTR_W:0]          qcount_t;

  // Classified word handed from the front end to the execution back end.
  typedef struct packed {
    op_t      op;
    logic     div_zero;
    operand_t a_real;
    operand_t a_imag;
    operand_t b_real;
    operand_t b_imag;
  } item_t;

endpackage

>>> hdl/cia_if.sv
// Valid/ready channel interfaces of the complex integer ALU.
// Depends on cia_pkg for the operand and result types.
interface cia_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  cia_pkg::operand_t a_real;
  cia_pkg::operand_t a_imag;
  cia_pkg::operand_t b_real;
  cia_pkg::operand_t b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cia_out_if;
  logic          valid;
  logic          ready;
  cia_pkg::res_t res_real;
  cia_pkg::res_t res_imag;
  logic          divide_error;

  modport source (output valid, res_real, res_imag, divide_error, input ready);
  modport sink   (input valid, res_real, res_imag, divide_error, output ready);
endinterface

>>> hdl/cia_front.sv
// Front end: accepts operand words, decodes the operation and flags a zero divisor.
// Depends on cia_pkg and cia_if.
module cia_front (
  input  logic            clk,
  input  logic            rst,
  cia_in_if.sink          operands,
  output cia_pkg::item_t  item,
  output logic            item_valid,
  input  logic            item_ready
);

  cia_pkg::item_t item_next;

  assign operands.ready = !item_valid || item_ready;

  always_comb begin
    item_next.op       = cia_pkg::op_t'(operands.action);
    item_next.a_real   = operands.a_real;
    item_next.a_imag   = operands.a_imag;
    item_next.b_real   = operands.b_real;
    item_next.b_imag   = operands.b_imag;
    item_next.div_zero = (item_next.op == cia_pkg::OP_DIV) &&
                         (operands.b_real == '0) && (operands.b_imag == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (operands.ready) begin
      item_valid <= operands.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (operands.valid && operands.ready) begin
      item <= item_next;
    end
  end

endmodule

>>> hdl/cia_queue.sv
// Small FIFO that decouples the front end from the execution back end.
// Depends on cia_pkg.
module cia_queue (
  input  logic            clk,
  input  logic            rst,
  input  cia_pkg::item_t  push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output cia_pkg::item_t  pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);

  cia_pkg::item_t   entries [cia_pkg::QUEUE_DEPTH];
  cia_pkg::qptr_t   wr_ptr;
  cia_pkg::qptr_t   rd_ptr;
  cia_pkg::qcount_t count;
  logic             push;
  logic             pop;

  assign push_ready = (count != cia_pkg::qcount_t'(cia_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cia_pkg::qcount_t'(cia_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    cia_pkg::qptr_t'(wr_ptr - rd_ptr) == count[cia_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

>>> hdl/cia_back.sv
// Execution back end: products, sums and a pipelined restoring divider pair.
// Depends on cia_pkg and cia_if.
module cia_back (
  input  logic            clk,
  input  logic            rst,
  input  cia_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_ready,
  cia_out_if.source       result
);

  typedef struct packed {
    logic              div;
    logic              err;
    cia_pkg::res_t     re;
    cia_pkg::res_t     im;
    logic              neg_re;
    logic              neg_im;
    cia_pkg::mag_t     den;
    cia_pkg::mag_t     rem_re;
    cia_pkg::mag_t     rem_im;
    cia_pkg::mag_t     nq_re;
    cia_pkg::mag_t     nq_im;
  } dstage_t;

  function automatic dstage_t div_step(dstage_t s);
    logic [cia_pkg::QW:0] r_re;
    logic [cia_pkg::QW:0] r_im;
    logic [cia_pkg::QW:0] d_ext;
    dstage_t              n;
    n     = s;
    d_ext = {1'b0, s.den};
    r_re  = {s.rem_re, s.nq_re[cia_pkg::QW-1]};
    r_im  = {s.rem_im, s.nq_im[cia_pkg::QW-1]};
    if (r_re >= d_ext) begin
      n.rem_re = cia_pkg::mag_t'(r_re - d_ext);
      n.nq_re  = {s.nq_re[cia_pkg::QW-2:0], 1'b1};
    end else begin
      n.rem_re = r_re[cia_pkg::QW-1:0];
      n.nq_re  = {s.nq_re[cia_pkg::QW-2:0], 1'b0};
    end
    if (r_im >= d_ext) begin
      n.rem_im = cia_pkg::mag_t'(r_im - d_ext);
      n.nq_im  = {s.nq_im[cia_pkg::QW-2:0], 1'b1};
    end else begin
      n.rem_im = r_im[cia_pkg::QW-1:0];
      n.nq_im  = {s.nq_im[cia_pkg::QW-2:0], 1'b0};
    end
    return n;
  endfunction

  logic en;

  // Product stage.
  logic           s1_v;
  cia_pkg::op_t   s1_op;
  logic           s1_err;
  cia_pkg::prod_t s1_ac, s1_bd, s1_ad, s1_bc, s1_cc, s1_dd;
  cia_pkg::ext_t  s1_lin_re, s1_lin_im;

  // Combine stage feeding the divider chain.
  cia_pkg::sum_t  mul_re, mul_im, num_re, num_im;
  cia_pkg::sum_t  abs_re, abs_im;
  cia_pkg::mag_t  den;
  dstage_t        ds_first;
  dstage_t        ds [cia_pkg::QW+1];
  logic [cia_pkg::QW:0] ds_v;

  cia_pkg::quo_t  q_re, q_im;

  assign en         = !result.valid || result.ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= item.op;
      s1_err <= item.div_zero;
      s1_ac  <= cia_pkg::prod_t'(item.a_real) * cia_pkg::prod_t'(item.b_real);
      s1_bd  <= cia_pkg::prod_t'(item.a_imag) * cia_pkg::prod_t'(item.b_imag);
      s1_ad  <= cia_pkg::prod_t'(item.a_real) * cia_pkg::prod_t'(item.b_imag);
      s1_bc  <= cia_pkg::prod_t'(item.a_imag) * cia_pkg::prod_t'(item.b_real);
      s1_cc  <= cia_pkg::prod_t'(item.b_real) * cia_pkg::prod_t'(item.b_real);
      s1_dd  <= cia_pkg::prod_t'(item.b_imag) * cia_pkg::prod_t'(item.b_imag);
      if (item.op == cia_pkg::OP_SUB) begin
        s1_lin_re <= cia_pkg::ext_t'(item.a_real) - cia_pkg::ext_t'(item.b_real);
        s1_lin_im <= cia_pkg::ext_t'(item.a_imag) - cia_pkg::ext_t'(item.b_imag);
      end else begin
        s1_lin_re <= cia_pkg::ext_t'(item.a_real) + cia_pkg::ext_t'(item.b_real);
        s1_lin_im <= cia_pkg::ext_t'(item.a_imag) + cia_pkg::ext_t'(item.b_imag);
      end
    end
  end

  always_comb begin
    mul_re = cia_pkg::sum_t'(s1_ac) - cia_pkg::sum_t'(s1_bd);
    mul_im = cia_pkg::sum_t'(s1_ad) + cia_pkg::sum_t'(s1_bc);
    num_re = cia_pkg::sum_t'(s1_ac) + cia_pkg::sum_t'(s1_bd);
    num_im = cia_pkg::sum_t'(s1_bc) - cia_pkg::sum_t'(s1_ad);
    abs_re = num_re[cia_pkg::PROD_W] ? -num_re : num_re;
    abs_im = num_im[cia_pkg::PROD_W] ? -num_im : num_im;
    den    = cia_pkg::mag_t'(s1_cc) + cia_pkg::mag_t'(s1_dd);

    ds_first.div    = (s1_op == cia_pkg::OP_DIV);
    ds_first.err    = s1_err;
    ds_first.neg_re = num_re[cia_pkg::PROD_W];
    ds_first.neg_im = num_im[cia_pkg::PROD_W];
    ds_first.den    = den;
    ds_first.rem_re = '0;
    ds_first.rem_im = '0;
    ds_first.nq_re  = abs_re[cia_pkg::QW-1:0];
    ds_first.nq_im  = abs_im[cia_pkg::QW-1:0];
    if (s1_op == cia_pkg::OP_MUL) begin
      ds_first.re = cia_pkg::res_t'(mul_re);
      ds_first.im = cia_pkg::res_t'(mul_im);
    end else begin
      ds_first.re = cia_pkg::res_t'(s1_lin_re);
      ds_first.im = cia_pkg::res_t'(s1_lin_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ds_v <= '0;
    end else if (en) begin
      ds_v <= {ds_v[cia_pkg::QW-1:0], s1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= ds_first;
    end
  end

  for (genvar k = 0; k < cia_pkg::QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        ds[k+1] <= div_step(ds[k]);
      end
    end
  end

  assign q_re = ds[cia_pkg::QW].neg_re ? -cia_pkg::quo_t'({1'b0, ds[cia_pkg::QW].nq_re})
                                       :  cia_pkg::quo_t'({1'b0, ds[cia_pkg::QW].nq_re});
  assign q_im = ds[cia_pkg::QW].neg_im ? -cia_pkg::quo_t'({1'b0, ds[cia_pkg::QW].nq_im})
                                       :  cia_pkg::quo_t'({1'b0, ds[cia_pkg::QW].nq_im});

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= ds_v[cia_pkg::QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!ds[cia_pkg::QW].div) begin
        result.res_real     <= ds[cia_pkg::QW].re;
        result.res_imag     <= ds[cia_pkg::QW].im;
        result.divide_error <= 1'b0;
      end else if (ds[cia_pkg::QW].err) begin
        result.res_real     <= '0;
        result.res_imag     <= '0;
        result.divide_error <= 1'b1;
      end else begin
        result.res_real     <= cia_pkg::res_t'(q_re);
        result.res_imag     <= cia_pkg::res_t'(q_im);
        result.divide_error <= 1'b0;
      end
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_error |-> result.res_real == '0 && result.res_imag == '0)
    else $error("divide error with nonzero result");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    en && ds_v[cia_pkg::QW] |=> result.valid)
    else $error("divider output word lost");

  a_err_div_only: assert property (@(posedge clk) disable iff (rst)
    s1_v && s1_err |-> s1_op == cia_pkg::OP_DIV)
    else $error("zero divisor flag on a non-divide word");

endmodule

>>> hdl/complex_integer_alu.sv
// Top level of the complex integer ALU: front end, decoupling queue, back end.
// Depends on cia_pkg, cia_if, cia_front, cia_queue and cia_back.
//
//   Channel    Direction  Payload
//   operands   in         action, a_real, a_imag, b_real, b_imag
//   result     out        res_real, res_imag, divide_error
//
// One word is accepted per cycle and one result leaves per cycle when the sink is ready.
// Every word passes through the front end register, the queue, the product stage and the
// divider chain of one restoring stage per quotient bit, then the result register.
// Reset (rst, synchronous) clears valid flags, queue pointers and the queue count only.
// A stalled result freezes the back end; the front end keeps filling the 4-word queue.
module complex_integer_alu (
  input logic        clk,
  input logic        rst,
  cia_in_if.sink     operands,
  cia_out_if.source  result
);

  // Front end register towards the queue.
  cia_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;

  // Queue head towards the back end.
  cia_pkg::item_t back_item;
  logic           back_valid;
  logic           back_ready;

  // The front end decodes the operation and detects a zero divisor once per word.
  cia_front u_front (
    .clk        (clk),
    .rst        (rst),
    .operands   (operands),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // The queue lets the front end keep accepting while the result side is stalled.
  cia_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // The back end computes all four operations in one fixed-length pipeline.
  cia_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .result     (result)
  );

endmodule
